// File: src/aavr_pkg.sv
package aavr_pkg;

    // coordinate format
    localparam int COORD_WIDTH       = 32;
    localparam int FRAC_BITS         = 16;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int MAX_CORDIC_STAGES = 32;

    // pi in Q62, rounded
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // pi scaled down by 2^sh, rounded to nearest
    function automatic logic [63:0] pi_const(input int sh);
        logic [64:0] acc;
        logic [64:0] res;
        acc = {1'b0, PI_Q62} + (65'd1 << (sh - 1));
        res = acc >> sh;
        return res[63:0];
    endfunction

    // reduced angle, Q(FRAC_BITS)
    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] TWO_PI  = ANG_W'(pi_const(61 - FRAC_BITS));
    localparam logic signed [ANG_W-1:0] PI_C    = ANG_W'(pi_const(62 - FRAC_BITS));
    localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(pi_const(63 - FRAC_BITS));
    localparam int RED_STEPS = COORD_WIDTH - $clog2(int'(TWO_PI));

    // cordic datapath, Q30
    localparam int ONE_SH = 30;
    localparam int XY_W   = 33;
    localparam int Z_W    = 34;

    localparam logic [31:0] ATAN_Q30 [MAX_CORDIC_STAGES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // unit-vector normalizer
    localparam int NORM_TOP = 29;
    localparam int M_W      = 30;
    localparam int ROOT_W   = 31;
    localparam int Q_W      = 33;
    localparam int DIV_W    = 64;
    localparam int RECIP_SH = 61;
    localparam int UNIT_LAT = 5 + ROOT_W + Q_W + 2;

    // rodrigues datapath
    localparam int PW = 72;
    localparam int RW = 40;
    localparam logic signed [RW-1:0] ONE_Q30 = RW'(64'd1 << ONE_SH);
    localparam logic signed [RW-1:0] SAT_HI  = RW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic signed [RW-1:0] SAT_LO  = -SAT_HI - RW'(1);
    localparam logic [COORD_WIDTH-1:0] OUT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] OUT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] vec;
        logic [2:0][COORD_WIDTH-1:0] axis;
        logic signed [ANG_W-1:0]     ang;
        logic                        neg;
    } t_item;

    // signed full product
    function automatic logic signed [PW-1:0] mulw(input logic signed [RW-1:0] a,
                                                 input logic signed [RW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    // product scaled by 2^-sh, rounded to nearest, ties away from zero
    function automatic logic signed [RW-1:0] rnd_shift(input logic signed [PW-1:0] p,
                                                      input int sh);
        logic [PW-1:0] m;
        m = (p < 0) ? PW'(-p) : PW'(p);
        m = (m + (PW'(1) << (sh - 1))) >> sh;
        return (p < 0) ? -RW'(m) : RW'(m);
    endfunction

endpackage

// File: src/aavr_front.sv
module aavr_front
    import aavr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [2:0][COORD_WIDTH-1:0] i_vec,
    input  logic [2:0][COORD_WIDTH-1:0] i_axis,
    input  logic [COORD_WIDTH-1:0]      i_angle,
    output logic                        o_valid,
    output t_item                       o_item
);

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] vec;
        logic [2:0][COORD_WIDTH-1:0] axis;
        logic [COORD_WIDTH-1:0]      rem;
        logic                        sgn;
    } t_red;

    t_red             r_red [RED_STEPS+1];
    logic [RED_STEPS:0] r_vld;

    // capture beat, split angle into sign and magnitude
    always_ff @(posedge i_clk) begin
        r_red[0].vec  <= i_vec;
        r_red[0].axis <= i_axis;
        r_red[0].sgn  <= i_angle[COORD_WIDTH-1];
        r_red[0].rem  <= i_angle[COORD_WIDTH-1] ? (~i_angle + COORD_WIDTH'(1)) : i_angle;
    end

    // remainder by two pi, one quotient bit per stage
    for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
        localparam logic [COORD_WIDTH:0] KS =
            (COORD_WIDTH+1)'(TWO_PI) << (RED_STEPS - 1 - j);
        always_ff @(posedge i_clk) begin
            r_red[j+1].vec  <= r_red[j].vec;
            r_red[j+1].axis <= r_red[j].axis;
            r_red[j+1].sgn  <= r_red[j].sgn;
            if ({1'b0, r_red[j].rem} >= KS) begin
                r_red[j+1].rem <= r_red[j].rem - KS[COORD_WIDTH-1:0];
            end else begin
                r_red[j+1].rem <= r_red[j].rem;
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[RED_STEPS-1:0], i_push};
            o_valid <= r_vld[RED_STEPS];
        end
    end

    // fold into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] n_r0, n_r1, n_r2;
    logic                    n_neg;
    always_comb begin
        n_r0 = signed'(r_red[RED_STEPS].rem[ANG_W-1:0]);
        if (r_red[RED_STEPS].sgn && (n_r0 != '0)) begin
            n_r0 = TWO_PI - n_r0;
        end
        n_r1 = (n_r0 > PI_C) ? (n_r0 - TWO_PI) : n_r0;
        n_neg = 1'b0;
        n_r2  = n_r1;
        if (n_r1 > HALF_PI) begin
            n_r2  = n_r1 - PI_C;
            n_neg = 1'b1;
        end else if (n_r1 < -HALF_PI) begin
            n_r2  = n_r1 + PI_C;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_item.vec  <= r_red[RED_STEPS].vec;
        o_item.axis <= r_red[RED_STEPS].axis;
        o_item.ang  <= n_r2;
        o_item.neg  <= n_neg;
    end

endmodule

// File: src/aavr_fifo.sv
module aavr_fifo
    import aavr_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_item o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push, w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: src/aavr_unit3.sv
module aavr_unit3
    import aavr_pkg::*;
#(
    parameter int IN_W    = COORD_WIDTH,
    parameter int FRAC_SH = FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [2:0][IN_W-1:0]        i_a,
    output logic [2:0][COORD_WIDTH-1:0] o_u
);

    localparam int POS_W = $clog2(IN_W);
    localparam int SH_W  = POS_W + 1;
    localparam int EXT_W = IN_W + M_W;
    localparam int PRD_W = M_W + Q_W;
    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << RECIP_SH;

    typedef struct packed {
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                zero;
    } t_uside;

    // magnitudes and common leading bit
    logic [2:0][IN_W-1:0] n1_mag, r1_mag;
    logic [2:0]           r1_neg;
    logic [IN_W-1:0]      r1_or;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_a[i][IN_W-1] ? (~i_a[i] + IN_W'(1)) : i_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mag <= n1_mag;
        for (int i = 0; i < 3; i++) begin
            r1_neg[i] <= i_a[i][IN_W-1];
        end
        r1_or <= n1_mag[0] | n1_mag[1] | n1_mag[2];
    end

    // leading bit position and normalizing shift
    logic [POS_W-1:0]     n2_pos;
    logic [2:0][IN_W-1:0] r2_mag;
    logic [2:0]           r2_neg;
    logic                 r2_zero;
    logic [SH_W-1:0]      r2_shl, r2_shr;

    always_comb begin
        n2_pos = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (r1_or[b]) begin
                n2_pos = POS_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mag  <= r1_mag;
        r2_neg  <= r1_neg;
        r2_zero <= (r1_or == '0);
        r2_shl  <= (SH_W'(n2_pos) < SH_W'(NORM_TOP)) ?
                   (SH_W'(NORM_TOP) - SH_W'(n2_pos)) : '0;
        r2_shr  <= (SH_W'(n2_pos) > SH_W'(NORM_TOP)) ?
                   (SH_W'(n2_pos) - SH_W'(NORM_TOP)) : '0;
    end

    // shift all three so the largest lies in [2^29, 2^30)
    t_uside n3_side, r3_side;
    always_comb begin
        logic [EXT_W-1:0] ext;
        ext = '0;
        n3_side.neg  = r2_neg;
        n3_side.zero = r2_zero;
        for (int i = 0; i < 3; i++) begin
            ext = (EXT_W'(r2_mag[i]) << r2_shl) >> r2_shr;
            n3_side.m[i] = ext[M_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_side <= n3_side;
    end

    // squares
    logic [2:0][2*M_W-1:0] r4_sq;
    t_uside                r4_side;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= (2*M_W)'(r3_side.m[i]) * (2*M_W)'(r3_side.m[i]);
        end
        r4_side <= r3_side;
    end

    // sum of squares, then root one bit per stage
    logic [DIV_W-1:0]  r_sr_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_sr_root [ROOT_W+1];
    t_uside            r_sr_side [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        r_sr_rem[0]  <= DIV_W'(r4_sq[0]) + DIV_W'(r4_sq[1]) + DIV_W'(r4_sq[2]);
        r_sr_root[0] <= '0;
        r_sr_side[0] <= r4_side;
    end

    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - s;
        logic [DIV_W-1:0] trial;
        assign trial = (DIV_W'(r_sr_root[s]) << (K + 1)) | (DIV_W'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            r_sr_side[s+1] <= r_sr_side[s];
            if (r_sr_rem[s] >= trial) begin
                r_sr_rem[s+1]  <= r_sr_rem[s] - trial;
                r_sr_root[s+1] <= r_sr_root[s] | (ROOT_W'(1) << K);
            end else begin
                r_sr_rem[s+1]  <= r_sr_rem[s];
                r_sr_root[s+1] <= r_sr_root[s];
            end
        end
    end

    // reciprocal of the root, one quotient bit per stage
    logic [DIV_W-1:0]  r_dv_rem [Q_W];
    logic [Q_W-1:0]    r_dv_q   [Q_W];
    logic [ROOT_W-1:0] r_dv_den [Q_W];
    t_uside            r_dv_side[Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int J = Q_W - 1 - s;
        logic [DIV_W-1:0]  rem_in;
        logic [Q_W-1:0]    q_in;
        logic [ROOT_W-1:0] den_in;
        t_uside            side_in;
        logic [DIV_W-1:0]  dsh;
        if (s == 0) begin : g_first
            assign rem_in  = RECIP_NUM;
            assign q_in    = '0;
            assign den_in  = r_sr_root[ROOT_W];
            assign side_in = r_sr_side[ROOT_W];
        end else begin : g_next
            assign rem_in  = r_dv_rem[s-1];
            assign q_in    = r_dv_q[s-1];
            assign den_in  = r_dv_den[s-1];
            assign side_in = r_dv_side[s-1];
        end
        assign dsh = DIV_W'(den_in) << J;
        always_ff @(posedge i_clk) begin
            r_dv_den[s]  <= den_in;
            r_dv_side[s] <= side_in;
            if (rem_in >= dsh) begin
                r_dv_rem[s] <= rem_in - dsh;
                r_dv_q[s]   <= q_in | (Q_W'(1) << J);
            end else begin
                r_dv_rem[s] <= rem_in;
                r_dv_q[s]   <= q_in;
            end
        end
    end

    // scale each component by the reciprocal
    logic [2:0][PRD_W-1:0] r_mp_prod;
    t_uside                r_mp_side;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mp_prod[i] <= PRD_W'(r_dv_side[Q_W-1].m[i]) * PRD_W'(r_dv_q[Q_W-1]);
        end
        r_mp_side <= r_dv_side[Q_W-1];
    end

    // restore signs, zero axis gives zero
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic [PRD_W-1:0] v;
            v = r_mp_prod[i] >> (RECIP_SH - FRAC_SH);
            if (r_mp_side.zero) begin
                o_u[i] <= '0;
            end else if (r_mp_side.neg[i]) begin
                o_u[i] <= -COORD_WIDTH'(v);
            end else begin
                o_u[i] <= COORD_WIDTH'(v);
            end
        end
    end

endmodule

// File: src/aavr_cordic.sv
module aavr_cordic
    import aavr_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES
) (
    input  logic                  i_clk,
    input  logic signed [Z_W-1:0] i_z,
    output logic [XY_W-1:0]       o_x,
    output logic [XY_W-1:0]       o_y
);

    localparam int NS = (STAGES > MAX_CORDIC_STAGES) ? MAX_CORDIC_STAGES : STAGES;
    localparam logic signed [XY_W-1:0] X_START = XY_W'(64'd1 << ONE_SH);

    logic signed [XY_W-1:0] r_x [NS];
    logic signed [XY_W-1:0] r_y [NS];
    logic signed [Z_W-1:0]  r_z [NS];

    // one micro-rotation per stage, direction from residual angle
    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [Z_W-1:0] T = Z_W'(ATAN_Q30[i]);
        logic signed [XY_W-1:0] x_in, y_in;
        logic signed [Z_W-1:0]  z_in;
        if (i == 0) begin : g_first
            assign x_in = X_START;
            assign y_in = '0;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (z_in >= 0) begin
                r_x[i] <= x_in - (y_in >>> i);
                r_y[i] <= y_in + (x_in >>> i);
                r_z[i] <= z_in - T;
            end else begin
                r_x[i] <= x_in + (y_in >>> i);
                r_y[i] <= y_in - (x_in >>> i);
                r_z[i] <= z_in + T;
            end
        end
    end

    assign o_x = r_x[NS-1];
    assign o_y = r_y[NS-1];

endmodule

// File: src/aavr_back.sv
module aavr_back
    import aavr_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_item                  i_item,
    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_x,
    output logic [COORD_WIDTH-1:0] o_y,
    output logic [COORD_WIDTH-1:0] o_z,
    output logic                   o_sat
);

    localparam int NS = (CORDIC_STAGES > MAX_CORDIC_STAGES) ?
                        MAX_CORDIC_STAGES : CORDIC_STAGES;
    localparam int SC_LAT = NS + UNIT_LAT;

    // angle into q30 for the cordic
    logic signed [Z_W-1:0]       w_z;
    logic [XY_W-1:0]             w_cx, w_cy;
    logic [2:0][XY_W-1:0]        w_cvec;
    logic [2:0][COORD_WIDTH-1:0] w_u, w_w;

    assign w_z    = Z_W'(i_item.ang) <<< (ONE_SH - FRAC_BITS);
    assign w_cvec = {XY_W'(0), w_cy, w_cx};

    aavr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk (i_clk),
        .i_z   (w_z),
        .o_x   (w_cx),
        .o_y   (w_cy)
    );

    aavr_unit3 #(.IN_W(XY_W), .FRAC_SH(ONE_SH)) u_sc_norm (
        .i_clk (i_clk),
        .i_a   (w_cvec),
        .o_u   (w_w)
    );

    aavr_unit3 #(.IN_W(COORD_WIDTH), .FRAC_SH(FRAC_BITS)) u_axis_norm (
        .i_clk (i_clk),
        .i_a   (i_item.axis),
        .o_u   (w_u)
    );

    // align unit axis and vector with sine and cosine
    logic [2:0][COORD_WIDTH-1:0] r_u_dly   [NS];
    logic [2:0][COORD_WIDTH-1:0] r_vec_dly [SC_LAT];
    logic [SC_LAT-1:0]           r_neg_dly;
    logic [SC_LAT-1:0]           r_vld_dly;

    always_ff @(posedge i_clk) begin
        r_u_dly[0]   <= w_u;
        r_vec_dly[0] <= i_item.vec;
        for (int i = 1; i < NS; i++) begin
            r_u_dly[i] <= r_u_dly[i-1];
        end
        for (int i = 1; i < SC_LAT; i++) begin
            r_vec_dly[i] <= r_vec_dly[i-1];
        end
        r_neg_dly <= {r_neg_dly[SC_LAT-2:0], i_item.neg};
    end

    // valid chain through the datapath
    logic [6:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_dly <= '0;
            r_vld     <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_vld_dly <= {r_vld_dly[SC_LAT-2:0], i_valid};
            r_vld     <= {r_vld[5:0], r_vld_dly[SC_LAT-1]};
            o_valid   <= r_vld[6];
        end
    end

    // s0: operands, sign of the fold applied
    logic signed [RW-1:0] r0_u [3], r0_v [3], r0_c, r0_s;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_u[i] <= RW'($signed(r_u_dly[NS-1][i]));
            r0_v[i] <= RW'($signed(r_vec_dly[SC_LAT-1][i]));
        end
        r0_c <= r_neg_dly[SC_LAT-1] ? -RW'($signed(w_w[0])) : RW'($signed(w_w[0]));
        r0_s <= r_neg_dly[SC_LAT-1] ? -RW'($signed(w_w[1])) : RW'($signed(w_w[1]));
    end

    // s1: cross, dot and v*cos products
    logic signed [PW-1:0] r1_pa [3], r1_pb [3], r1_pd [3], r1_pvc [3];
    logic signed [RW-1:0] r1_u [3], r1_s, r1_omc;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_pa[i]  <= mulw(r0_u[(i+1)%3], r0_v[(i+2)%3]);
            r1_pb[i]  <= mulw(r0_u[(i+2)%3], r0_v[(i+1)%3]);
            r1_pd[i]  <= mulw(r0_u[i], r0_v[i]);
            r1_pvc[i] <= mulw(r0_v[i], r0_c);
            r1_u[i]   <= r0_u[i];
        end
        r1_s   <= r0_s;
        r1_omc <= ONE_Q30 - r0_c;
    end

    // s2: round cross, dot and v*cos
    logic signed [RW-1:0] r2_cr [3], r2_vc [3], r2_u [3], r2_d, r2_s, r2_omc;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_cr[i] <= rnd_shift(r1_pa[i], FRAC_BITS) - rnd_shift(r1_pb[i], FRAC_BITS);
            r2_vc[i] <= rnd_shift(r1_pvc[i], ONE_SH);
            r2_u[i]  <= r1_u[i];
        end
        r2_d   <= rnd_shift(r1_pd[0], FRAC_BITS) + rnd_shift(r1_pd[1], FRAC_BITS)
                  + rnd_shift(r1_pd[2], FRAC_BITS);
        r2_s   <= r1_s;
        r2_omc <= r1_omc;
    end

    // s3: cross*sin and dot*(1-cos)
    logic signed [PW-1:0] r3_pcs [3], r3_pt;
    logic signed [RW-1:0] r3_u [3], r3_vc [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_pcs[i] <= mulw(r2_cr[i], r2_s);
            r3_u[i]   <= r2_u[i];
            r3_vc[i]  <= r2_vc[i];
        end
        r3_pt <= mulw(r2_d, r2_omc);
    end

    // s4: round them
    logic signed [RW-1:0] r4_cs [3], r4_u [3], r4_vc [3], r4_t;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_cs[i] <= rnd_shift(r3_pcs[i], ONE_SH);
            r4_u[i]  <= r3_u[i];
            r4_vc[i] <= r3_vc[i];
        end
        r4_t <= rnd_shift(r3_pt, ONE_SH);
    end

    // s5: axis times projection term
    logic signed [PW-1:0] r5_put [3];
    logic signed [RW-1:0] r5_cs [3], r5_vc [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_put[i] <= mulw(r4_u[i], r4_t);
            r5_cs[i]  <= r4_cs[i];
            r5_vc[i]  <= r4_vc[i];
        end
    end

    // s6: sum of the three terms
    logic signed [RW-1:0] r6_r [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_r[i] <= r5_vc[i] + r5_cs[i] + rnd_shift(r5_put[i], FRAC_BITS);
        end
    end

    // s7: clip to the output range
    logic [2:0][COORD_WIDTH-1:0] n7_out;
    logic [2:0]                  n7_clip;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_clip[i] = 1'b1;
            if (r6_r[i] > SAT_HI) begin
                n7_out[i] = OUT_MAX;
            end else if (r6_r[i] < SAT_LO) begin
                n7_out[i] = OUT_MIN;
            end else begin
                n7_out[i]  = COORD_WIDTH'(r6_r[i]);
                n7_clip[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_x   <= n7_out[0];
        o_y   <= n7_out[1];
        o_z   <= n7_out[2];
        o_sat <= r_vld[6] && (n7_clip != '0);
    end

endmodule

// File: src/axis_angle_vector_rotate.sv
// Axis-angle vector rotation, one beat in and one beat out per item.
// Input: drive vector, axis (any length, zero allowed) and angle in radians,
// all signed Q16.16, and raise start; the beat is taken at a clock edge where
// start is high and busy is low.
// Output: the rotated vector appears on o_out_x/y/z for exactly one cycle with
// o_valid high; o_saturated flags a component clipped to the 32-bit range.
// There is no stall on the output side; results come in input order.
// Throughput: one item per clock. busy rises only if the queue between the
// front and the rotation datapath fills, which the datapath never lets happen.
// The path runs through angle reduction and fold, the queue,
// then CORDIC_STAGES cordic stages, the unit-vector normalizer
// (31 root steps and 33 reciprocal steps) and the rodrigues datapath s0 to s7.
// Reset empties the queue and clears every valid; no item is kept.
module axis_angle_vector_rotate
    import aavr_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_vec_x,
    input  logic [COORD_WIDTH-1:0] i_vec_y,
    input  logic [COORD_WIDTH-1:0] i_vec_z,
    input  logic [COORD_WIDTH-1:0] i_axis_x,
    input  logic [COORD_WIDTH-1:0] i_axis_y,
    input  logic [COORD_WIDTH-1:0] i_axis_z,
    input  logic [COORD_WIDTH-1:0] i_angle,
    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_out_x,
    output logic [COORD_WIDTH-1:0] o_out_y,
    output logic [COORD_WIDTH-1:0] o_out_z,
    output logic                   o_saturated
);

    logic  w_front_valid, w_fifo_empty, w_fifo_full;
    t_item w_front_item, w_fifo_item;

    assign busy = w_fifo_full;

    // accept and reduce the angle
    aavr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !busy),
        .i_vec   ({i_vec_z, i_vec_y, i_vec_x}),
        .i_axis  ({i_axis_z, i_axis_y, i_axis_x}),
        .i_angle (i_angle),
        .o_valid (w_front_valid),
        .o_item  (w_front_item)
    );

    // queue between front and datapath
    aavr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_item),
        .i_pop   (!w_fifo_empty),
        .o_empty (w_fifo_empty),
        .o_full  (w_fifo_full),
        .o_data  (w_fifo_item)
    );

    // rotation datapath
    aavr_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_fifo_empty),
        .i_item  (w_fifo_item),
        .o_valid (o_valid),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_sat   (o_saturated)
    );

    // no beat from the front is ever dropped at the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_front_valid && w_fifo_full))
        else $error("queue overflow");

    // the saturation flag only rides on a result beat
    a_sat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_valid)
        else $error("saturated without result");

    // a clipped result holds a range end in some component
    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_out_x == OUT_MAX || o_out_x == OUT_MIN ||
                         o_out_y == OUT_MAX || o_out_y == OUT_MIN ||
                         o_out_z == OUT_MAX || o_out_z == OUT_MIN))
        else $error("saturated result not at range end");

endmodule

// File: tb/sv/tb.sv
module tb;
    import aavr_pkg::*;

    typedef struct {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   sat;
    } rotated_t;

    localparam int STAGES = DEF_CORDIC_STAGES;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [COORD_WIDTH-1:0] i_vec_x = '0;
    logic [COORD_WIDTH-1:0] i_vec_y = '0;
    logic [COORD_WIDTH-1:0] i_vec_z = '0;
    logic [COORD_WIDTH-1:0] i_axis_x = '0;
    logic [COORD_WIDTH-1:0] i_axis_y = '0;
    logic [COORD_WIDTH-1:0] i_axis_z = '0;
    logic [COORD_WIDTH-1:0] i_angle = '0;
    logic                   o_valid;
    logic [COORD_WIDTH-1:0] o_out_x;
    logic [COORD_WIDTH-1:0] o_out_y;
    logic [COORD_WIDTH-1:0] o_out_z;
    logic                   o_saturated;

    rotated_t expected_rotations[$];
    int       fail_count = 0;

    // arctan table, Q30
    const logic [31:0] arctan_q30[32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
        32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
    };

    axis_angle_vector_rotate dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .i_axis_x(i_axis_x), .i_axis_y(i_axis_y), .i_axis_z(i_axis_z),
        .i_angle(i_angle), .o_valid(o_valid), .o_out_x(o_out_x),
        .o_out_y(o_out_y), .o_out_z(o_out_z), .o_saturated(o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // magnitude of a signed value
    function automatic longint unsigned abs_val(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // pi scaled down by 2^sh, rounded
    function automatic longint pi_scaled(int sh);
        logic [64:0] acc;
        acc = {1'b0, 64'hC90FDAA22168C235} + (65'd1 << (sh - 1));
        return longint'(acc >> sh);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // a*b/2^sh, rounded half away from zero, magnitude clamped to 2^62
    function automatic longint scaled_mul(longint a, longint b, int sh);
        logic [127:0] prod;
        logic [127:0] mag;
        prod = {64'd0, abs_val(a)} * {64'd0, abs_val(b)};
        mag = (prod + (128'd1 << (sh - 1))) >> sh;
        if (mag > (128'd1 << 62)) mag = 128'd1 << 62;
        return ((a < 0) != (b < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // unit vector with frac fraction bits
    task automatic make_unit(input longint a[3], input int frac, output longint u[3]);
        longint unsigned m[3];
        longint unsigned top, sum, root, recip, v;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = abs_val(a[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) begin
            u = '{0, 0, 0};
            return;
        end
        while (top >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            top = top >> 1;
        end
        while (top < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            top = top << 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = int_sqrt(sum);
        recip = (64'd1 << 61) / root;
        for (int i = 0; i < 3; i++) begin
            v = (m[i] * recip) >> (61 - frac);
            u[i] = a[i] < 0 ? -longint'(v) : longint'(v);
        end
    endtask

    // cosine and sine in Q30 after reduction and fold
    task automatic cos_sin(input longint ang, output longint c, output longint s);
        longint two_pi, pi, half_pi, r, x, y, z, xs, ys, t;
        longint pv[3];
        longint pu[3];
        logic   flip;
        two_pi = pi_scaled(61 - FRAC_BITS);
        pi = pi_scaled(62 - FRAC_BITS);
        half_pi = pi_scaled(63 - FRAC_BITS);
        r = ang % two_pi;
        flip = 1'b0;
        if (r < 0) r = r + two_pi;
        if (r > pi) r = r - two_pi;
        if (r > half_pi) begin
            r = r - pi;
            flip = 1'b1;
        end else if (r < -half_pi) begin
            r = r + pi;
            flip = 1'b1;
        end
        z = r * (64'sd1 <<< (30 - FRAC_BITS));
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            t = longint'(arctan_q30[i]);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - t;
            end else begin
                x = x + ys; y = y - xs; z = z + t;
            end
        end
        pv = '{x, y, 0};
        make_unit(pv, 30, pu);
        c = flip ? -pu[0] : pu[0];
        s = flip ? -pu[1] : pu[1];
    endtask

    // rodrigues rotation of one beat
    task automatic predict_rotation(input logic [31:0] vec[3], input logic [31:0] ax[3],
                                    input logic [31:0] ang, output rotated_t res);
        longint v[3];
        longint a[3];
        longint u[3];
        longint cr[3];
        longint c, s, d, t, r, hi, lo;
        logic [31:0] o[3];
        hi = 64'sd2147483647;
        lo = -hi - 1;
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'(signed'(vec[i]));
            a[i] = longint'(signed'(ax[i]));
        end
        make_unit(a, FRAC_BITS, u);
        cos_sin(longint'(signed'(ang)), c, s);
        cr[0] = scaled_mul(u[1], v[2], FRAC_BITS) - scaled_mul(u[2], v[1], FRAC_BITS);
        cr[1] = scaled_mul(u[2], v[0], FRAC_BITS) - scaled_mul(u[0], v[2], FRAC_BITS);
        cr[2] = scaled_mul(u[0], v[1], FRAC_BITS) - scaled_mul(u[1], v[0], FRAC_BITS);
        d = scaled_mul(u[0], v[0], FRAC_BITS) + scaled_mul(u[1], v[1], FRAC_BITS)
            + scaled_mul(u[2], v[2], FRAC_BITS);
        t = scaled_mul(d, (64'sd1 <<< 30) - c, 30);
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r = scaled_mul(v[i], c, 30) + scaled_mul(cr[i], s, 30)
                + scaled_mul(u[i], t, FRAC_BITS);
            if (r > hi) begin
                r = hi;
                res.sat = 1'b1;
            end else if (r < lo) begin
                r = lo;
                res.sat = 1'b1;
            end
            o[i] = r[31:0];
        end
        res.x = o[0];
        res.y = o[1];
        res.z = o[2];
    endtask

    // send one beat, predict it once accepted
    task automatic send_rotation(input logic [31:0] vx, vy, vz, ax, ay, az, ang);
        rotated_t res;
        logic [31:0] v[3];
        logic [31:0] a[3];
        @(negedge i_clk);
        start <= 1'b1;
        i_vec_x <= vx; i_vec_y <= vy; i_vec_z <= vz;
        i_axis_x <= ax; i_axis_y <= ay; i_axis_z <= az;
        i_angle <= ang;
        do @(posedge i_clk); while (busy);
        v = '{vx, vy, vz};
        a = '{ax, ay, az};
        predict_rotation(v, a, ang, res);
        expected_rotations.push_back(res);
    endtask

    // random idle between beats: mostly none, some short, few long
    task automatic idle_gap();
        int pick, n;
        pick = $urandom_range(99);
        n = pick < 60 ? 0 : (pick < 94 ? $urandom_range(3, 1) : $urandom_range(60, 15));
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic end_beat();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // check each result against the oldest prediction
    always @(posedge i_clk) begin
        rotated_t e;
        if (i_rst_n && o_valid) begin
            if (expected_rotations.size() == 0) begin
                $error("unexpected result x=%h y=%h z=%h", o_out_x, o_out_y, o_out_z);
                fail_count++;
            end else begin
                e = expected_rotations.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %h actual %h", e.x, o_out_x);
                    fail_count++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %h actual %h", e.y, o_out_y);
                    fail_count++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z expected %h actual %h", e.z, o_out_z);
                    fail_count++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated expected %b actual %b", e.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    localparam logic [31:0] MAXV = 32'h7FFFFFFF;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONE  = 32'h00010000;
    localparam logic [31:0] HPI  = 32'h0001921F;
    localparam logic [31:0] PIV  = 32'h0003243F;

    // field extremes and angle landmarks
    task automatic test_extremes();
        send_rotation(0, 0, 0, 0, 0, 0, 0);
        send_rotation(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_rotation(MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_rotation(ONE, 0, 0, 0, 0, ONE, HPI);
        send_rotation(ONE, ONE, 0, 0, 0, ONE, PIV);
        send_rotation(ONE, 0, ONE, 0, ONE, 0, -PIV);
        send_rotation(0, ONE, 0, ONE, 0, 0, -HPI);
        send_rotation(ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, 32'h00064880);
        send_rotation(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 0, 0, 1);
        end_beat();
    endtask

    // zero axis, huge axis, saturation
    task automatic test_special_cases();
        send_rotation(ONE, 32'hFFFF0000, 5 * ONE, 0, 0, 0, HPI);
        send_rotation(3 * ONE, 7 * ONE, ONE, 0, 0, 0, PIV);
        send_rotation(ONE, ONE, ONE, MAXV, 0, 0, HPI);
        send_rotation(ONE, 2 * ONE, ONE, MINV, MAXV, 32'h40000000, 32'h00012345);
        send_rotation(MAXV, MAXV, 0, 0, 0, ONE, 32'h0000C90F);
        send_rotation(MINV, MINV, MINV, 0, 0, ONE, 32'h0000C90F);
        send_rotation(MAXV, 0, 0, 0, 0, 0, PIV);
        send_rotation(MINV, 0, 0, 1, 1, 1, 32'h7FFF0000);
        send_rotation(ONE, ONE, ONE, 1, 0, 0, MINV);
        end_beat();
    endtask

    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 32'(signed'($urandom_range(32'h01FFFFFF)) - 32'sh00FFFFFF);
        if (pick < 9) return $urandom();
        return pick[0] ? MAXV : MINV;
    endfunction

    task automatic test_random(int count);
        logic [31:0] ang;
        for (int n = 0; n < count; n++) begin
            ang = ($urandom_range(3) == 0) ? $urandom()
                  : 32'(signed'($urandom_range(32'h000FFFFF)) - 32'sh0007FFFF);
            send_rotation(rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(7) == 0 ? 32'd0 : rand_coord(),
                          $urandom_range(7) == 0 ? 32'd0 : rand_coord(),
                          $urandom_range(7) == 0 ? 32'd0 : rand_coord(), ang);
            idle_gap();
        end
        end_beat();
    endtask

    // sender holds off until the pipeline is empty
    task automatic test_drain_pause();
        while (expected_rotations.size() != 0) @(negedge i_clk);
        test_random(20);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_special_cases();
        test_random(400);
        test_drain_pause();
        test_random(380);
        while (expected_rotations.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/aavr_pkg.sv
src/aavr_front.sv
src/aavr_fifo.sv
src/aavr_unit3.sv
src/aavr_cordic.sv
src/aavr_back.sv
src/axis_angle_vector_rotate.sv
tb/sv/tb.sv
